### rtl/psst_pkg.sv
package psst_pkg;

   localparam int SENSORS    = 128;
   localparam int COUNT_BITS = 16;
   localparam int ADDR_W     = $clog2(SENSORS);
   localparam int USED_W     = $clog2(SENSORS + 1);

   localparam logic [1:0] FN_RECORD  = 2'd0;
   localparam logic [1:0] FN_QUERY   = 2'd1;
   localparam logic [1:0] FN_SUMMARY = 2'd2;
   localparam logic [1:0] FN_NONE    = 2'd3;

   localparam logic [1:0] KIND_TEMP   = 2'd0;
   localparam logic [1:0] KIND_HUMID  = 2'd1;
   localparam logic [1:0] KIND_ENERGY = 2'd2;

   localparam logic [1:0] LVL_ALERT    = 2'd1;
   localparam logic [1:0] LVL_CRITICAL = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_UNKNOWN = 2'd2;

   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   typedef struct packed {
      logic [1:0]         func;
      logic [15:0]        sensor_tag;
      logic [1:0]         kind;
      logic [1:0]         level;
      logic signed [23:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [15:0]        result_id;
      logic signed [23:0] mean;
      logic [22:0]        std_dev;
      logic [15:0]        count;
      logic [31:0]        alerts;
      logic [31:0]        criticals;
      logic signed [47:0] energy_sum;
      logic [7:0]         sensors_in_use;
   } rsp_type;

   // one table entry, stored as one memory row
   typedef struct packed {
      logic [15:0]           key;
      logic signed [39:0]    tsum;
      logic [63:0]           tsq;
      logic [COUNT_BITS-1:0] tcnt;
      logic signed [39:0]    hsum;
      logic [63:0]           hsq;
      logic [COUNT_BITS-1:0] hcnt;
      logic signed [39:0]    esum;
      logic [COUNT_BITS-1:0] ecnt;
      logic [COUNT_BITS-1:0] acnt;
      logic [COUNT_BITS-1:0] ccnt;
   } row_type;

   typedef enum logic [3:0] {
      S_IDLE, S_FIND_RD, S_FIND_CMP, S_MISS, S_UPDATE, S_REPORT,
      S_REPORT_WAIT, S_SCAN_RD, S_SCAN_CHK, S_SCAN_WAIT
   } st_type;

   typedef enum logic [2:0] {
      MS_IDLE, MS_DIV_SUM, MS_DIV_SQ, MS_SQUARE, MS_VAR, MS_ROOT, MS_DONE
   } mst_type;

endpackage

### rtl/psst_ram.sv
module psst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/psst_moments.sv
module psst_moments
   import psst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [39:0]    sum,
   input  logic [63:0]           sq,
   input  logic [COUNT_BITS-1:0] n,
   input  logic                  squares,
   output logic                  done,
   output logic signed [23:0]    mean,
   output logic [22:0]           sd
);

   mst_type state_ff, state_in;
   logic [5:0]            cnt_ff;
   logic [63:0]           dvd_ff;
   logic [34:0]           rem_ff;
   logic [31:0]           root_ff;
   logic [COUNT_BITS-1:0] n_ff;
   logic                  neg_ff, squares_ff;
   logic [63:0]           sq_ff;
   logic signed [23:0]    mean_ff;
   logic [47:0]           m2_ff;
   logic [22:0]           sd_ff;

   // shared shift-subtract unit: division and square root steps
   logic [34:0] sub_a, sub_b;
   logic [35:0] diff;
   logic        borrow;
   logic [63:0] quot;
   logic [23:0] mag;
   logic [39:0] abs_sum;
   logic signed [23:0] mean_sat;

   always_comb begin
      if (state_ff == MS_ROOT) begin
         sub_a = {rem_ff[32:0], dvd_ff[63:62]};
         sub_b = {1'b0, root_ff, 2'b01};
      end else begin
         sub_a = {rem_ff[33:0], dvd_ff[63]};
         sub_b = {{(35 - COUNT_BITS){1'b0}}, n_ff};
      end
      diff    = {1'b0, sub_a} - {1'b0, sub_b};
      borrow  = diff[35];
      quot    = {dvd_ff[62:0], ~borrow};
      mag     = neg_ff ? (~mean_ff + 24'd1) : mean_ff;
      abs_sum = sum[39] ? (~sum + 40'd1) : sum;
      if (neg_ff) begin
         mean_sat = (quot > 64'd8388608) ? -24'sd8388608 : -$signed(quot[23:0]);
      end else begin
         mean_sat = (quot > 64'd8388607) ? 24'sd8388607 : $signed(quot[23:0]);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         MS_IDLE:    if (start) state_in = (n == '0) ? MS_DONE : MS_DIV_SUM;
         MS_DIV_SUM: if (cnt_ff == 6'd63) begin
            state_in = (!squares_ff || n_ff < COUNT_BITS'(2)) ? MS_DONE : MS_DIV_SQ;
         end
         MS_DIV_SQ:  if (cnt_ff == 6'd63) state_in = MS_SQUARE;
         MS_SQUARE:  state_in = MS_VAR;
         MS_VAR:     state_in = MS_ROOT;
         MS_ROOT:    if (cnt_ff == 6'd31) state_in = MS_DONE;
         MS_DONE:    state_in = MS_IDLE;
         default:    state_in = MS_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      done = (state_ff == MS_DONE);
      mean = mean_ff;
      sd   = sd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         MS_IDLE: if (start) begin
            dvd_ff     <= {24'd0, abs_sum};
            rem_ff     <= '0;
            cnt_ff     <= '0;
            n_ff       <= n;
            neg_ff     <= sum[39];
            sq_ff      <= sq;
            squares_ff <= squares;
            mean_ff    <= '0;
            sd_ff      <= '0;
         end
         MS_DIV_SUM, MS_DIV_SQ: begin
            if (cnt_ff == 6'd63) begin
               rem_ff <= '0;
               cnt_ff <= '0;
               if (state_ff == MS_DIV_SUM) begin
                  mean_ff <= mean_sat;
                  dvd_ff  <= sq_ff;
               end else begin
                  dvd_ff  <= quot;
               end
            end else begin
               cnt_ff <= cnt_ff + 6'd1;
               rem_ff <= borrow ? sub_a : diff[34:0];
               dvd_ff <= quot;
            end
         end
         MS_SQUARE: begin
            m2_ff  <= mag * mag;
         end
         MS_VAR: begin
            dvd_ff  <= (dvd_ff > {16'd0, m2_ff}) ? dvd_ff - {16'd0, m2_ff} : '0;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
         end
         MS_ROOT: begin
            cnt_ff  <= cnt_ff + 6'd1;
            dvd_ff  <= {dvd_ff[61:0], 2'b00};
            rem_ff  <= borrow ? sub_a : diff[34:0];
            root_ff <= {root_ff[30:0], ~borrow};
            if (cnt_ff == 6'd31) begin
               sd_ff <= ({root_ff[30:0], ~borrow} > 32'd8388607) ? 23'h7FFFFF
                        : {root_ff[21:0], ~borrow};
            end
         end
         default: begin
         end
      endcase
   end

endmodule

### rtl/per_sensor_statistics_table.sv
// Channel   Ports                     Handshake
// request   start, busy, req_data     taken when start is high and busy is low
// response  rsp_valid, rsp_data       one-cycle strobe, no back-pressure
//
// Record and query walk the key table one entry at a time (one memory
// read port), then the moments unit runs up to two 64-step divisions
// and a 32-step square root on one shared subtractor.
// Summary walks every entry and runs the moments unit for each entry with
// two or more temperature samples.
// Synchronous reset empties the table at once; busy stays high until the
// response strobe.
module per_sensor_statistics_table
   import psst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   st_type state_ff, state_in;
   req_type            req_ff;
   logic [47:0]        vsq_ff;
   logic [USED_W-1:0]  idx_ff, used_ff;
   row_type            row_ff, row_upd, rd_row, row_blank;
   logic [31:0]        tot_al_ff, tot_cr_ff;
   logic signed [47:0] tot_en_ff, tot_en_upd;
   logic [31:0]        tot_al_upd, tot_cr_upd;
   rsp_type            rsp_ff, rsp_blank;
   logic               rsp_valid_ff;
   logic               found_ff;
   logic [15:0]        best_id_ff;
   logic signed [23:0] best_mean_ff;
   logic [22:0]        best_sd_ff;
   logic [COUNT_BITS-1:0] best_n_ff;

   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_addr;
   logic [$bits(row_type)-1:0] ram_rdata;

   logic                  mom_start, mom_done, mom_sq;
   logic signed [39:0]    mom_sum;
   logic [63:0]           mom_sqs;
   logic [COUNT_BITS-1:0] mom_n, rep_n;
   logic signed [23:0]    mom_mean;
   logic [22:0]           mom_sd;

   logic accept, hit, at_end, full, is_alert, is_crit;

   assign rd_row = row_type'(ram_rdata);
   assign accept = start && !busy;
   assign hit    = (rd_row.key == req_ff.sensor_tag);
   assign at_end = (idx_ff == used_ff);
   assign full   = (used_ff == USED_W'(SENSORS));
   assign ram_addr = idx_ff[ADDR_W-1:0];

   psst_ram #(.WIDTH($bits(row_type)), .DEPTH(SENSORS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_addr),
      .wdata (row_upd),
      .raddr (ram_addr),
      .rdata (ram_rdata)
   );

   psst_moments u_mom (
      .clock   (clock),
      .reset   (reset),
      .start   (mom_start),
      .sum     (mom_sum),
      .sq      (mom_sqs),
      .n       (mom_n),
      .squares (mom_sq),
      .done    (mom_done),
      .mean    (mom_mean),
      .sd      (mom_sd)
   );

   // apply one reading to the current row and the totals
   always_comb begin
      logic signed [40:0] s41;
      logic signed [48:0] s49;
      logic [64:0]        q65;
      logic signed [39:0] sum_sel;
      logic [63:0]        sq_sel;
      row_upd    = row_ff;
      tot_en_upd = tot_en_ff;
      tot_al_upd = tot_al_ff;
      tot_cr_upd = tot_cr_ff;
      sum_sel = (req_ff.kind == KIND_TEMP) ? row_ff.tsum
              : (req_ff.kind == KIND_HUMID) ? row_ff.hsum : row_ff.esum;
      sq_sel  = (req_ff.kind == KIND_TEMP) ? row_ff.tsq : row_ff.hsq;
      s41 = {sum_sel[39], sum_sel} + {{17{req_ff.value[23]}}, req_ff.value};
      q65 = {1'b0, sq_sel} + {17'd0, vsq_ff};
      s49 = {tot_en_ff[47], tot_en_ff} + {{25{req_ff.value[23]}}, req_ff.value};
      if (s41[40] != s41[39]) begin
         s41[39:0] = s41[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
      end
      if (q65[64]) begin
         q65[63:0] = '1;
      end
      if (s49[48] != s49[47]) begin
         s49[47:0] = s49[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end
      case (req_ff.kind)
         KIND_TEMP: if (row_ff.tcnt != CNT_MAX) begin
            row_upd.tsum = s41[39:0];
            row_upd.tsq  = q65[63:0];
            row_upd.tcnt = row_ff.tcnt + 1'b1;
         end
         KIND_HUMID: if (row_ff.hcnt != CNT_MAX) begin
            row_upd.hsum = s41[39:0];
            row_upd.hsq  = q65[63:0];
            row_upd.hcnt = row_ff.hcnt + 1'b1;
         end
         KIND_ENERGY: if (row_ff.ecnt != CNT_MAX) begin
            row_upd.esum = s41[39:0];
            row_upd.ecnt = row_ff.ecnt + 1'b1;
            tot_en_upd   = s49[47:0];
         end
         default: begin
         end
      endcase
      if ((is_alert || is_crit) && row_ff.acnt != CNT_MAX) begin
         row_upd.acnt = row_ff.acnt + 1'b1;
         if (tot_al_ff != '1) tot_al_upd = tot_al_ff + 32'd1;
      end
      if (is_crit && row_ff.ccnt != CNT_MAX) begin
         row_upd.ccnt = row_ff.ccnt + 1'b1;
         if (tot_cr_ff != '1) tot_cr_upd = tot_cr_ff + 32'd1;
      end
   end

   assign is_alert = (req_ff.level == LVL_ALERT);
   assign is_crit  = (req_ff.level == LVL_CRITICAL);

   // build the blank response word and the fresh table row
   always_comb begin
      rsp_blank = '0;
      rsp_blank.status = ST_UNKNOWN;
      rsp_blank.sensors_in_use = 8'(used_ff);
      if (state_ff == S_MISS) begin
         rsp_blank.result_id = req_ff.sensor_tag;
         if (req_ff.func == FN_RECORD) rsp_blank.status = ST_FULL;
      end
      row_blank = '0;
      row_blank.key = req_ff.sensor_tag;
   end

   // pick the moments operands of the selected kind
   always_comb begin
      mom_sum = '0;
      mom_sqs = '0;
      rep_n   = '0;
      mom_sq  = 1'b1;
      if (state_ff == S_SCAN_CHK) begin
         mom_sum = rd_row.tsum;
         mom_sqs = rd_row.tsq;
         rep_n   = rd_row.tcnt;
      end else begin
         case (req_ff.kind)
            KIND_TEMP:   begin mom_sum = row_ff.tsum; mom_sqs = row_ff.tsq; rep_n = row_ff.tcnt; end
            KIND_HUMID:  begin mom_sum = row_ff.hsum; mom_sqs = row_ff.hsq; rep_n = row_ff.hcnt; end
            KIND_ENERGY: begin mom_sum = row_ff.esum; mom_sq = 1'b0; rep_n = row_ff.ecnt; end
            default:     mom_sq = 1'b0;
         endcase
      end
      mom_n = rep_n;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) begin
            if (req_data.func == FN_RECORD || req_data.func == FN_QUERY) state_in = S_FIND_RD;
            else if (req_data.func == FN_SUMMARY) state_in = S_SCAN_RD;
         end
         S_FIND_RD:  state_in = at_end ? S_MISS : S_FIND_CMP;
         S_FIND_CMP: if (hit) begin
            state_in = (req_ff.func == FN_RECORD) ? S_UPDATE : S_REPORT;
         end else begin
            state_in = S_FIND_RD;
         end
         S_MISS:     state_in = (req_ff.func == FN_RECORD && !full) ? S_UPDATE : S_IDLE;
         S_UPDATE:   state_in = S_REPORT;
         S_REPORT:   state_in = S_REPORT_WAIT;
         S_REPORT_WAIT: if (mom_done) state_in = S_IDLE;
         S_SCAN_RD:  state_in = at_end ? S_IDLE : S_SCAN_CHK;
         S_SCAN_CHK: state_in = (rd_row.tcnt < COUNT_BITS'(2)) ? S_SCAN_RD : S_SCAN_WAIT;
         S_SCAN_WAIT: if (mom_done) state_in = S_SCAN_RD;
         default:    state_in = S_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      busy      = (state_ff != S_IDLE);
      ram_we    = (state_ff == S_UPDATE);
      mom_start = (state_ff == S_REPORT) ||
                  (state_ff == S_SCAN_CHK && rd_row.tcnt >= COUNT_BITS'(2));
      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         tot_al_ff    <= '0;
         tot_cr_ff    <= '0;
         tot_en_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (state_ff == S_MISS && req_ff.func == FN_RECORD && !full) begin
            used_ff <= used_ff + 1'b1;
         end
         if (state_ff == S_UPDATE) begin
            tot_al_ff <= tot_al_upd;
            tot_cr_ff <= tot_cr_upd;
            tot_en_ff <= tot_en_upd;
         end
         rsp_valid_ff <= (state_ff == S_IDLE && accept && req_data.func == FN_NONE) ||
                         (state_ff == S_MISS && !(req_ff.func == FN_RECORD && !full)) ||
                         (state_ff == S_REPORT_WAIT && mom_done) ||
                         (state_ff == S_SCAN_RD && at_end);
      end
   end

   // payload registers and the response word
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: if (accept) begin
            req_ff   <= req_data;
            vsq_ff   <= 48'(req_data.value * req_data.value);
            idx_ff   <= '0;
            found_ff <= 1'b0;
            best_id_ff   <= '0;
            best_mean_ff <= '0;
            best_sd_ff   <= '0;
            best_n_ff    <= '0;
            rsp_ff       <= rsp_blank;
         end
         S_FIND_CMP: begin
            row_ff <= rd_row;
            if (!hit) idx_ff <= idx_ff + 1'b1;
         end
         S_MISS: begin
            row_ff <= row_blank;
            rsp_ff <= rsp_blank;
         end
         S_UPDATE: row_ff <= row_upd;
         S_REPORT_WAIT: if (mom_done) begin
            rsp_ff.status     <= ST_OK;
            rsp_ff.result_id  <= row_ff.key;
            rsp_ff.mean       <= mom_mean;
            rsp_ff.std_dev    <= mom_sd;
            rsp_ff.count      <= 16'(rep_n);
            rsp_ff.alerts     <= 32'(row_ff.acnt);
            rsp_ff.criticals  <= 32'(row_ff.ccnt);
            rsp_ff.energy_sum <= {{8{row_ff.esum[39]}}, row_ff.esum};
            rsp_ff.sensors_in_use <= 8'(used_ff);
         end
         S_SCAN_RD: if (at_end) begin
            rsp_ff.status     <= found_ff ? ST_OK : ST_UNKNOWN;
            rsp_ff.result_id  <= best_id_ff;
            rsp_ff.mean       <= best_mean_ff;
            rsp_ff.std_dev    <= best_sd_ff;
            rsp_ff.count      <= 16'(best_n_ff);
            rsp_ff.alerts     <= tot_al_ff;
            rsp_ff.criticals  <= tot_cr_ff;
            rsp_ff.energy_sum <= tot_en_ff;
            rsp_ff.sensors_in_use <= 8'(used_ff);
         end
         S_SCAN_CHK: begin
            row_ff <= rd_row;
            if (rd_row.tcnt < COUNT_BITS'(2)) idx_ff <= idx_ff + 1'b1;
         end
         S_SCAN_WAIT: if (mom_done) begin
            idx_ff <= idx_ff + 1'b1;
            if (!found_ff || mom_sd > best_sd_ff ||
                (mom_sd == best_sd_ff && row_ff.key < best_id_ff)) begin
               found_ff     <= 1'b1;
               best_id_ff   <= row_ff.key;
               best_mean_ff <= mom_mean;
               best_sd_ff   <= mom_sd;
               best_n_ff    <= row_ff.tcnt;
            end
         end
         default: begin
         end
      endcase
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(SENSORS)) else $error("table fill count overflow");
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response strobe while still working");
   a_used_reported: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.sensors_in_use == 8'(used_ff))
      else $error("reported fill count stale");
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIND_CMP || state_ff == S_SCAN_CHK) |-> idx_ff < used_ff)
      else $error("read past filled entries");

endmodule
